### rtl/core/rgk_pkg.sv
// ----------------------------------------------------------------------------
// rgk_pkg
// Widths, item types and stage records shared by the reflected Green kernel
// evaluator and its square-root and divider pipelines.
// ----------------------------------------------------------------------------
package rgk_pkg;

  localparam int unsigned CRD_W  = 32;  // coordinate, Q2.29
  localparam int unsigned WT_W   = 32;  // weight or Jacobian, Q4.27
  localparam int unsigned FRAC_C = 29;
  localparam int unsigned FRAC_W = 27;

  localparam int unsigned SQ_W   = 36;  // squared-norm and dot terms
  localparam int unsigned WAB_W  = 37;  // wa*wb, Q.27
  localparam int unsigned WJ_W   = 42;  // wa*wb*j, Q.27
  localparam int unsigned DEN_W  = 44;  // denominator, Q.29
  localparam int unsigned PX_W   = 40;  // |y|^2 x_i and d_i
  localparam int unsigned DN_W   = 44;  // d.n, Q.29

  localparam int unsigned SQ_SH  = 21;
  localparam int unsigned RAD_W  = 64;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned ROOT_H = ROOT_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 3;

  localparam int unsigned DMAG_W = DEN_W - 1;
  localparam int unsigned E_W    = DMAG_W + ROOT_W;
  localparam int unsigned MD_H   = DN_W / 2;
  localparam int unsigned PR_W   = WJ_W + DN_W;
  localparam int unsigned NUM_SH = 37;
  localparam int unsigned NUM_W  = 128;
  localparam int unsigned QUO_W  = 64;
  localparam int unsigned KV_W   = 64;

  localparam logic signed [DEN_W-1:0] ONE_Q =
    {{(DEN_W-FRAC_C-1){1'b0}}, 1'b1, {FRAC_C{1'b0}}};
  localparam logic [KV_W-1:0] KV_MAX = {1'b0, {(KV_W-1){1'b1}}};
  localparam logic [KV_W-1:0] KV_MIN = {1'b1, {(KV_W-1){1'b0}}};

  typedef struct packed {
    logic signed [CRD_W-1:0] point_a_x;
    logic signed [CRD_W-1:0] point_a_y;
    logic signed [CRD_W-1:0] point_a_z;
    logic signed [CRD_W-1:0] normal_x;
    logic signed [CRD_W-1:0] normal_y;
    logic signed [CRD_W-1:0] normal_z;
    logic signed [CRD_W-1:0] point_b_x;
    logic signed [CRD_W-1:0] point_b_y;
    logic signed [CRD_W-1:0] point_b_z;
    logic signed [WT_W-1:0]  weight_a;
    logic signed [WT_W-1:0]  weight_b;
    logic signed [WT_W-1:0]  jacobian_b;
  } in_item_t;

  typedef struct packed {
    logic signed [KV_W-1:0] kernel_value;
    logic                   saturated;
  } out_item_t;

  // carried alongside the square root
  typedef struct packed {
    logic [DMAG_W-1:0] den_mag;
    logic [WJ_W-1:0]   wj_mag;
    logic [DN_W-1:0]   dn_mag;
    logic              neg;
    logic              bad;
  } sq_side_t;

  // carried alongside the divider
  typedef struct packed {
    logic neg;
    logic bad;
    logic ovf;
  } dv_side_t;

endpackage

### rtl/core/reflected_green_kernel_eval.sv
// ----------------------------------------------------------------------------
// reflected_green_kernel_eval
// Normal-derivative kernel of the reflected Green function for one point pair.
// ----------------------------------------------------------------------------
// Takes one point pair per clock while in_stall is low and returns one
// kernel entry per pair, in order. From input transfer to the output, an
// item passes six arithmetic stages (products, sums, |x|^2|y|^2, den and
// d, d.n, final sum), a 32-stage square root of den*2^21, two stages
// forming den*sqrt and the numerator, a 64-stage divider, and the output
// register. A two-entry output buffer lets the pipeline keep running while
// one result waits; in_stall rises only when both entries are full.
// Non-positive den gives zero with saturated set; results outside the
// signed 64-bit range clamp and set saturated.
module reflected_green_kernel_eval (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rgk_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rgk_pkg::out_item_t  out_data
);

  logic adv;

  // stage 1: products
  logic signed [rgk_pkg::CRD_W-1:0]     x_in [3];
  logic signed [rgk_pkg::CRD_W-1:0]     y_in [3];
  logic signed [rgk_pkg::CRD_W-1:0]     n_in [3];
  logic signed [2*rgk_pkg::CRD_W-1:0]   pxx [3];
  logic signed [2*rgk_pkg::CRD_W-1:0]   pyy [3];
  logic signed [2*rgk_pkg::CRD_W-1:0]   pxy [3];
  logic signed [2*rgk_pkg::WT_W-1:0]    pwab;
  logic signed [rgk_pkg::SQ_W-1:0]      s1_xx_nxt [3];
  logic signed [rgk_pkg::SQ_W-1:0]      s1_yy_nxt [3];
  logic signed [rgk_pkg::SQ_W-1:0]      s1_xy_nxt [3];
  logic signed [rgk_pkg::WAB_W-1:0]     s1_wab_nxt;
  logic                                 s1_v_r;
  logic signed [rgk_pkg::SQ_W-1:0]      s1_xx_r [3];
  logic signed [rgk_pkg::SQ_W-1:0]      s1_yy_r [3];
  logic signed [rgk_pkg::SQ_W-1:0]      s1_xy_r [3];
  logic signed [rgk_pkg::WAB_W-1:0]     s1_wab_r;
  logic signed [rgk_pkg::CRD_W-1:0]     s1_x_r [3];
  logic signed [rgk_pkg::CRD_W-1:0]     s1_y_r [3];
  logic signed [rgk_pkg::CRD_W-1:0]     s1_n_r [3];
  logic signed [rgk_pkg::WT_W-1:0]      s1_jb_r;

  // stage 2: norms, dot, wa*wb*j
  logic signed [rgk_pkg::WAB_W+rgk_pkg::WT_W-1:0] pwj;
  logic signed [rgk_pkg::SQ_W-1:0]      s2_nx_nxt, s2_ny_nxt, s2_xy_nxt;
  logic signed [rgk_pkg::WJ_W-1:0]      s2_wj_nxt;
  logic                                 s2_v_r;
  logic signed [rgk_pkg::SQ_W-1:0]      s2_nx_r, s2_ny_r, s2_xy_r;
  logic signed [rgk_pkg::WJ_W-1:0]      s2_wj_r;
  logic signed [rgk_pkg::CRD_W-1:0]     s2_x_r [3];
  logic signed [rgk_pkg::CRD_W-1:0]     s2_y_r [3];
  logic signed [rgk_pkg::CRD_W-1:0]     s2_n_r [3];

  // stage 3: |x|^2|y|^2, |y|^2 x_i, 1 - 2 x.y
  logic signed [2*rgk_pkg::SQ_W-1:0]    pnn;
  logic signed [rgk_pkg::SQ_W+rgk_pkg::CRD_W-1:0] ppx [3];
  logic signed [rgk_pkg::DEN_W-1:0]     xy_ext;
  logic signed [rgk_pkg::DEN_W-1:0]     s3_nn_nxt, s3_dp_nxt;
  logic signed [rgk_pkg::PX_W-1:0]      s3_px_nxt [3];
  logic                                 s3_v_r;
  logic signed [rgk_pkg::DEN_W-1:0]     s3_nn_r, s3_dp_r;
  logic signed [rgk_pkg::PX_W-1:0]      s3_px_r [3];
  logic signed [rgk_pkg::CRD_W-1:0]     s3_y_r [3];
  logic signed [rgk_pkg::CRD_W-1:0]     s3_n_r [3];
  logic signed [rgk_pkg::WJ_W-1:0]      s3_wj_r;

  // stage 4: den, d
  logic signed [rgk_pkg::DEN_W-1:0]     s4_den_nxt;
  logic signed [rgk_pkg::PX_W-1:0]      s4_d_nxt [3];
  logic                                 s4_v_r;
  logic signed [rgk_pkg::DEN_W-1:0]     s4_den_r;
  logic signed [rgk_pkg::PX_W-1:0]      s4_d_r [3];
  logic signed [rgk_pkg::CRD_W-1:0]     s4_n_r [3];
  logic signed [rgk_pkg::WJ_W-1:0]      s4_wj_r;

  // stage 5: d_i n_i
  logic signed [rgk_pkg::PX_W+rgk_pkg::CRD_W-1:0] pdn [3];
  logic signed [rgk_pkg::DN_W-1:0]      s5_dt_nxt [3];
  logic                                 s5_v_r;
  logic signed [rgk_pkg::DN_W-1:0]      s5_dt_r [3];
  logic signed [rgk_pkg::DEN_W-1:0]     s5_den_r;
  logic signed [rgk_pkg::WJ_W-1:0]      s5_wj_r;

  // stage 6: d.n
  logic signed [rgk_pkg::DN_W-1:0]      s6_dn_nxt;
  logic                                 s6_v_r;
  logic signed [rgk_pkg::DN_W-1:0]      s6_dn_r;
  logic signed [rgk_pkg::DEN_W-1:0]     s6_den_r;
  logic signed [rgk_pkg::WJ_W-1:0]      s6_wj_r;

  // square root
  logic [rgk_pkg::RAD_W-1:0]            sq_rad;
  rgk_pkg::sq_side_t                    sq_side;
  logic                                 sq_vld;
  logic [rgk_pkg::ROOT_W-1:0]           sq_root;
  rgk_pkg::sq_side_t                    sq_oside;

  // den*sqrt and numerator partial products, then sums
  logic [rgk_pkg::DMAG_W+rgk_pkg::ROOT_H-1:0] m1_elo_nxt, m1_ehi_nxt;
  logic [rgk_pkg::WJ_W+rgk_pkg::MD_H-1:0]     m1_nlo_nxt, m1_nhi_nxt;
  logic                                 m1_v_r;
  logic [rgk_pkg::DMAG_W+rgk_pkg::ROOT_H-1:0] m1_elo_r, m1_ehi_r;
  logic [rgk_pkg::WJ_W+rgk_pkg::MD_H-1:0]     m1_nlo_r, m1_nhi_r;
  logic                                 m1_neg_r, m1_bad_r;
  logic [rgk_pkg::PR_W-1:0]             m2_prod;
  logic [rgk_pkg::E_W-1:0]              m2_e_nxt;
  logic [rgk_pkg::NUM_W-1:0]            m2_num_nxt;
  logic                                 m2_v_r;
  logic [rgk_pkg::E_W-1:0]              m2_e_r;
  logic [rgk_pkg::NUM_W-1:0]            m2_num_r;
  logic                                 m2_neg_r, m2_bad_r;

  // divider
  logic [rgk_pkg::E_W-1:0]              dv_rem;
  rgk_pkg::dv_side_t                    dv_side;
  logic                                 dv_vld;
  logic [rgk_pkg::QUO_W-1:0]            dv_quo;
  rgk_pkg::dv_side_t                    dv_oside;

  // output buffer
  rgk_pkg::out_item_t                   res;
  logic                                 push, pop;
  logic                                 head_v_r, head_v_nxt;
  logic                                 spare_v_r, spare_v_nxt;
  rgk_pkg::out_item_t                   head_r, head_nxt;
  rgk_pkg::out_item_t                   spare_r, spare_nxt;

  assign adv      = ~spare_v_r;
  assign in_stall = spare_v_r;

  // ---- stage 1
  always_comb begin
    x_in[0] = in_data.point_a_x;
    x_in[1] = in_data.point_a_y;
    x_in[2] = in_data.point_a_z;
    n_in[0] = in_data.normal_x;
    n_in[1] = in_data.normal_y;
    n_in[2] = in_data.normal_z;
    y_in[0] = in_data.point_b_x;
    y_in[1] = in_data.point_b_y;
    y_in[2] = in_data.point_b_z;
    for (int i = 0; i < 3; i++) begin
      pxx[i] = x_in[i] * x_in[i];
      pyy[i] = y_in[i] * y_in[i];
      pxy[i] = x_in[i] * y_in[i];
      s1_xx_nxt[i] = rgk_pkg::SQ_W'(pxx[i] >>> rgk_pkg::FRAC_C);
      s1_yy_nxt[i] = rgk_pkg::SQ_W'(pyy[i] >>> rgk_pkg::FRAC_C);
      s1_xy_nxt[i] = rgk_pkg::SQ_W'(pxy[i] >>> rgk_pkg::FRAC_C);
    end
    pwab       = in_data.weight_a * in_data.weight_b;
    s1_wab_nxt = rgk_pkg::WAB_W'(pwab >>> rgk_pkg::FRAC_W);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_xx_r  <= s1_xx_nxt;
      s1_yy_r  <= s1_yy_nxt;
      s1_xy_r  <= s1_xy_nxt;
      s1_wab_r <= s1_wab_nxt;
      s1_x_r   <= x_in;
      s1_y_r   <= y_in;
      s1_n_r   <= n_in;
      s1_jb_r  <= in_data.jacobian_b;
    end
  end

  // ---- stage 2
  always_comb begin
    s2_nx_nxt = s1_xx_r[0] + s1_xx_r[1] + s1_xx_r[2];
    s2_ny_nxt = s1_yy_r[0] + s1_yy_r[1] + s1_yy_r[2];
    s2_xy_nxt = s1_xy_r[0] + s1_xy_r[1] + s1_xy_r[2];
    pwj       = s1_wab_r * s1_jb_r;
    s2_wj_nxt = rgk_pkg::WJ_W'(pwj >>> rgk_pkg::FRAC_W);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_nx_r <= s2_nx_nxt;
      s2_ny_r <= s2_ny_nxt;
      s2_xy_r <= s2_xy_nxt;
      s2_wj_r <= s2_wj_nxt;
      s2_x_r  <= s1_x_r;
      s2_y_r  <= s1_y_r;
      s2_n_r  <= s1_n_r;
    end
  end

  // ---- stage 3
  always_comb begin
    pnn       = s2_nx_r * s2_ny_r;
    s3_nn_nxt = rgk_pkg::DEN_W'(pnn >>> rgk_pkg::FRAC_C);
    for (int i = 0; i < 3; i++) begin
      ppx[i]       = s2_ny_r * s2_x_r[i];
      s3_px_nxt[i] = rgk_pkg::PX_W'(ppx[i] >>> rgk_pkg::FRAC_C);
    end
    xy_ext    = rgk_pkg::DEN_W'(s2_xy_r);
    s3_dp_nxt = rgk_pkg::ONE_Q - (xy_ext <<< 1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_nn_r <= s3_nn_nxt;
      s3_dp_r <= s3_dp_nxt;
      s3_px_r <= s3_px_nxt;
      s3_y_r  <= s2_y_r;
      s3_n_r  <= s2_n_r;
      s3_wj_r <= s2_wj_r;
    end
  end

  // ---- stage 4
  always_comb begin
    s4_den_nxt = s3_dp_r + s3_nn_r;
    for (int i = 0; i < 3; i++) begin
      s4_d_nxt[i] = s3_px_r[i] - rgk_pkg::PX_W'(s3_y_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_den_r <= s4_den_nxt;
      s4_d_r   <= s4_d_nxt;
      s4_n_r   <= s3_n_r;
      s4_wj_r  <= s3_wj_r;
    end
  end

  // ---- stage 5
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pdn[i]       = s4_d_r[i] * s4_n_r[i];
      s5_dt_nxt[i] = rgk_pkg::DN_W'(pdn[i] >>> rgk_pkg::FRAC_C);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_dt_r  <= s5_dt_nxt;
      s5_den_r <= s4_den_r;
      s5_wj_r  <= s4_wj_r;
    end
  end

  // ---- stage 6
  assign s6_dn_nxt = s5_dt_r[0] + s5_dt_r[1] + s5_dt_r[2];

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_dn_r  <= s6_dn_nxt;
      s6_den_r <= s5_den_r;
      s6_wj_r  <= s5_wj_r;
    end
  end

  // ---- square root of den*2^21
  always_comb begin
    sq_rad          = {s6_den_r[rgk_pkg::RAD_W-rgk_pkg::SQ_SH-1:0], {rgk_pkg::SQ_SH{1'b0}}};
    sq_side.den_mag = s6_den_r[rgk_pkg::DMAG_W-1:0];
    sq_side.wj_mag  = s6_wj_r[rgk_pkg::WJ_W-1] ? rgk_pkg::WJ_W'(-s6_wj_r)
                                               : rgk_pkg::WJ_W'(s6_wj_r);
    sq_side.dn_mag  = s6_dn_r[rgk_pkg::DN_W-1] ? rgk_pkg::DN_W'(-s6_dn_r)
                                               : rgk_pkg::DN_W'(s6_dn_r);
    sq_side.neg     = (s6_wj_r[rgk_pkg::WJ_W-1] == s6_dn_r[rgk_pkg::DN_W-1]);
    sq_side.bad     = s6_den_r[rgk_pkg::DEN_W-1] || (s6_den_r == '0);
  end

  rgk_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (s6_v_r),
    .in_rad   (sq_rad),
    .in_side  (sq_side),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_oside)
  );

  // ---- partial products
  always_comb begin
    m1_elo_nxt = sq_oside.den_mag * sq_root[rgk_pkg::ROOT_H-1:0];
    m1_ehi_nxt = sq_oside.den_mag * sq_root[rgk_pkg::ROOT_W-1:rgk_pkg::ROOT_H];
    m1_nlo_nxt = sq_oside.wj_mag * sq_oside.dn_mag[rgk_pkg::MD_H-1:0];
    m1_nhi_nxt = sq_oside.wj_mag * sq_oside.dn_mag[rgk_pkg::DN_W-1:rgk_pkg::MD_H];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_elo_r <= m1_elo_nxt;
      m1_ehi_r <= m1_ehi_nxt;
      m1_nlo_r <= m1_nlo_nxt;
      m1_nhi_r <= m1_nhi_nxt;
      m1_neg_r <= sq_oside.neg;
      m1_bad_r <= sq_oside.bad;
    end
  end

  // ---- den*sqrt and numerator
  always_comb begin
    m2_e_nxt   = rgk_pkg::E_W'(m1_elo_r) + (rgk_pkg::E_W'(m1_ehi_r) << rgk_pkg::ROOT_H);
    m2_prod    = rgk_pkg::PR_W'(m1_nlo_r) + (rgk_pkg::PR_W'(m1_nhi_r) << rgk_pkg::MD_H);
    m2_num_nxt = rgk_pkg::NUM_W'(m2_prod) << rgk_pkg::NUM_SH;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_e_r   <= m2_e_nxt;
      m2_num_r <= m2_num_nxt;
      m2_neg_r <= m1_neg_r;
      m2_bad_r <= m1_bad_r;
    end
  end

  // ---- divider; high quotient word nonzero means overflow
  always_comb begin
    dv_rem      = rgk_pkg::E_W'(m2_num_r[rgk_pkg::NUM_W-1:rgk_pkg::QUO_W]);
    dv_side.neg = m2_neg_r;
    dv_side.bad = m2_bad_r;
    dv_side.ovf = (dv_rem >= m2_e_r);
  end

  rgk_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (m2_v_r),
    .in_rem   (dv_rem),
    .in_lo    (m2_num_r[rgk_pkg::QUO_W-1:0]),
    .in_dvs   (m2_e_r),
    .in_side  (dv_side),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_oside)
  );

  // ---- sign, clamp
  always_comb begin
    res.kernel_value = '0;
    res.saturated    = 1'b0;
    priority if (dv_oside.bad) begin
      res.saturated = 1'b1;
    end else if (dv_oside.ovf) begin
      res.saturated    = 1'b1;
      res.kernel_value = dv_oside.neg ? rgk_pkg::KV_MIN : rgk_pkg::KV_MAX;
    end else if (!dv_oside.neg) begin
      if (dv_quo[rgk_pkg::QUO_W-1]) begin
        res.saturated    = 1'b1;
        res.kernel_value = rgk_pkg::KV_MAX;
      end else begin
        res.kernel_value = dv_quo;
      end
    end else begin
      if (dv_quo[rgk_pkg::QUO_W-1] && (dv_quo[rgk_pkg::QUO_W-2:0] != '0)) begin
        res.saturated    = 1'b1;
        res.kernel_value = rgk_pkg::KV_MIN;
      end else begin
        res.kernel_value = '0 - dv_quo;
      end
    end
  end

  // ---- valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      m1_v_r <= sq_vld;
      m2_v_r <= m1_v_r;
    end
  end

  // ---- two-entry output buffer
  always_comb begin
    pop         = head_v_r & ~out_stall;
    push        = adv & dv_vld;
    head_v_nxt  = head_v_r;
    head_nxt    = head_r;
    spare_v_nxt = spare_v_r;
    spare_nxt   = spare_r;
    if (!head_v_r || pop) begin
      if (spare_v_r) begin
        head_v_nxt  = 1'b1;
        head_nxt    = spare_r;
        spare_v_nxt = 1'b0;
      end else begin
        head_v_nxt  = push;
        head_nxt    = res;
      end
    end else if (push) begin
      spare_v_nxt = 1'b1;
      spare_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r  <= 1'b0;
      spare_v_r <= 1'b0;
    end else begin
      head_v_r  <= head_v_nxt;
      spare_v_r <= spare_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r  <= head_nxt;
    spare_r <= spare_nxt;
  end

  assign out_valid = head_v_r;
  assign out_data  = head_r;

  // ---- assertions
  a_spare_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v_r |-> head_v_r)
    else $error("spare entry holds a transfer while head is empty");

  a_spare_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
    spare_v_r |-> $past(out_stall))
    else $error("spare entry filled without an output stall");

  a_hold_on_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> s1_v_r)
    else $error("item dropped from first stage during freeze");

endmodule

### rtl/core/rgk_sqrt.sv
// ----------------------------------------------------------------------------
// rgk_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rgk_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_vld,
  input  logic [rgk_pkg::RAD_W-1:0]      in_rad,
  input  rgk_pkg::sq_side_t              in_side,
  output logic                           out_vld,
  output logic [rgk_pkg::ROOT_W-1:0]     out_root,
  output rgk_pkg::sq_side_t              out_side
);

  localparam int unsigned NSTG = rgk_pkg::ROOT_W;

  logic                          vld_r  [NSTG];
  logic [rgk_pkg::REM_W-1:0]     rem_r  [NSTG];
  logic [rgk_pkg::ROOT_W-1:0]    root_r [NSTG];
  logic [rgk_pkg::RAD_W-1:0]     rad_r  [NSTG];
  rgk_pkg::sq_side_t             side_r [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic                          p_vld;
    logic [rgk_pkg::REM_W-1:0]     p_rem;
    logic [rgk_pkg::ROOT_W-1:0]    p_root;
    logic [rgk_pkg::RAD_W-1:0]     p_rad;
    rgk_pkg::sq_side_t             p_side;
    logic [rgk_pkg::REM_W-1:0]     rem2;
    logic [rgk_pkg::REM_W-1:0]     trial;
    logic                          ge;
    logic [rgk_pkg::REM_W-1:0]     rem_nxt;

    if (s == 0) begin : g_head
      assign p_vld  = in_vld;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_rad  = in_rad;
      assign p_side = in_side;
    end else begin : g_body
      assign p_vld  = vld_r[s-1];
      assign p_rem  = rem_r[s-1];
      assign p_root = root_r[s-1];
      assign p_rad  = rad_r[s-1];
      assign p_side = side_r[s-1];
    end

    always_comb begin
      rem2    = {p_rem[rgk_pkg::REM_W-3:0], p_rad[rgk_pkg::RAD_W-1 -: 2]};
      trial   = {{(rgk_pkg::REM_W-rgk_pkg::ROOT_W-2){1'b0}}, p_root, 2'b01};
      ge      = (rem2 >= trial);
      rem_nxt = ge ? (rem2 - trial) : rem2;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s]  <= rem_nxt;
        root_r[s] <= {p_root[rgk_pkg::ROOT_W-2:0], ge};
        rad_r[s]  <= p_rad << 2;
        side_r[s] <= p_side;
      end
    end
  end

  assign out_vld  = vld_r[NSTG-1];
  assign out_root = root_r[NSTG-1];
  assign out_side = side_r[NSTG-1];

endmodule

### rtl/core/rgk_div.sv
// ----------------------------------------------------------------------------
// rgk_div
// Pipelined restoring divider, one quotient bit per stage, for the low
// quotient word once the high word is known to be zero.
// ----------------------------------------------------------------------------
module rgk_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_vld,
  input  logic [rgk_pkg::E_W-1:0]     in_rem,
  input  logic [rgk_pkg::QUO_W-1:0]   in_lo,
  input  logic [rgk_pkg::E_W-1:0]     in_dvs,
  input  rgk_pkg::dv_side_t           in_side,
  output logic                        out_vld,
  output logic [rgk_pkg::QUO_W-1:0]   out_quo,
  output rgk_pkg::dv_side_t           out_side
);

  localparam int unsigned NSTG = rgk_pkg::QUO_W;

  logic                          vld_r  [NSTG];
  logic [rgk_pkg::E_W-1:0]       rem_r  [NSTG];
  logic [rgk_pkg::QUO_W-1:0]     lo_r   [NSTG];
  logic [rgk_pkg::E_W-1:0]       dvs_r  [NSTG];
  logic [rgk_pkg::QUO_W-1:0]     quo_r  [NSTG];
  rgk_pkg::dv_side_t             side_r [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic                          p_vld;
    logic [rgk_pkg::E_W-1:0]       p_rem;
    logic [rgk_pkg::QUO_W-1:0]     p_lo;
    logic [rgk_pkg::E_W-1:0]       p_dvs;
    logic [rgk_pkg::QUO_W-1:0]     p_quo;
    rgk_pkg::dv_side_t             p_side;
    logic [rgk_pkg::E_W:0]         rem2;
    logic [rgk_pkg::E_W:0]         diff;
    logic                          ge;
    logic [rgk_pkg::E_W-1:0]       rem_nxt;

    if (s == 0) begin : g_head
      assign p_vld  = in_vld;
      assign p_rem  = in_rem;
      assign p_lo   = in_lo;
      assign p_dvs  = in_dvs;
      assign p_quo  = '0;
      assign p_side = in_side;
    end else begin : g_body
      assign p_vld  = vld_r[s-1];
      assign p_rem  = rem_r[s-1];
      assign p_lo   = lo_r[s-1];
      assign p_dvs  = dvs_r[s-1];
      assign p_quo  = quo_r[s-1];
      assign p_side = side_r[s-1];
    end

    always_comb begin
      rem2    = {p_rem, p_lo[rgk_pkg::QUO_W-1]};
      diff    = rem2 - {1'b0, p_dvs};
      ge      = (rem2 >= {1'b0, p_dvs});
      rem_nxt = ge ? diff[rgk_pkg::E_W-1:0] : rem2[rgk_pkg::E_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s]  <= rem_nxt;
        lo_r[s]   <= p_lo << 1;
        dvs_r[s]  <= p_dvs;
        quo_r[s]  <= {p_quo[rgk_pkg::QUO_W-2:0], ge};
        side_r[s] <= p_side;
      end
    end
  end

  assign out_vld  = vld_r[NSTG-1];
  assign out_quo  = quo_r[NSTG-1];
  assign out_side = side_r[NSTG-1];

endmodule
